/* hdl/hcbp_pkg.sv */
`default_nettype none

package hcbp_pkg;

    localparam int MAX_CODE_LEN = 32;
    localparam int COUNT_WIDTH  = 48;

    localparam int BYTE_BITS    = 8;
    localparam int SYM_WIDTH    = 8;
    localparam int CODE_WIDTH   = 32;
    localparam int LEN_WIDTH    = 6;
    localparam int TABLE_DEPTH  = 256;
    localparam int PEND_WIDTH   = 7;
    localparam int PCNT_WIDTH   = 3;
    localparam int PAD_WIDTH    = 3;
    localparam int TOTAL_WIDTH  = 48;
    localparam int ACC_WIDTH    = PEND_WIDTH + CODE_WIDTH;
    localparam int REM_WIDTH    = 6;

    // longest code a load may carry: capped by the code word port too
    localparam int LOAD_LEN_LIMIT = (MAX_CODE_LEN < CODE_WIDTH) ? MAX_CODE_LEN : CODE_WIDTH;

    typedef enum logic [1:0] {
        MODE_ENCODE = 2'd0,
        MODE_LOAD   = 2'd1,
        MODE_FLUSH  = 2'd2
    } mode_t;

    // one batch of bytes handed from the packer to the emitter
    typedef struct packed {
        logic [ACC_WIDTH-1:0] acc;
        logic [REM_WIDTH-1:0] rem;
        logic                 data_valid;
        logic [PAD_WIDTH-1:0] pad;
    } emit_t;

endpackage

`default_nettype wire

/* hdl/huffman_code_bit_packer_unit.sv */
`default_nettype none

// huffman code bit packer: each input transaction is a load (mode 1) that writes one
// symbol's code word and length into a 256-entry table, an encode (mode 0) that looks
// the symbol up and appends its code msb-first to the bit buffer, or a flush (mode 2)
// that left-aligns the partial byte with zero padding; mode 3 and loads longer than
// the maximum code length are dropped without a result. an encode gives 0 to 4 output
// transactions (one per completed byte), a flush always gives exactly one, with
// byte_valid low when nothing was pending; last marks the final output of an input.
// the table sits in a synchronous ram read at accept time, so an input passes through
// the table read and the packing stage (which owns the pending bits), then goes to the
// byte emitter and the output register. input takes one transaction per cycle as long
// as the emitter keeps up: an item that yields bytes holds the emitter until its last
// byte goes into the output register, and the next item that yields bytes waits in the
// packing stage until the emitter frees up. items that yield no bytes (loads, short
// codes, absent symbols) never wait on the output side. no clearing pass after reset:
// reset clears the table's presence bits. total_bytes saturates at the counter max.

module huffman_code_bit_packer_unit (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [1:0]                       mode,
    input  wire logic [hcbp_pkg::SYM_WIDTH-1:0]   symbol,
    input  wire logic [hcbp_pkg::CODE_WIDTH-1:0]  code_word,
    input  wire logic [hcbp_pkg::LEN_WIDTH-1:0]   code_length,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic      [hcbp_pkg::BYTE_BITS-1:0]   out_byte,
    output logic                                  byte_valid,
    output logic      [hcbp_pkg::PAD_WIDTH-1:0]   pad_bits,
    output logic                                  last,
    output logic      [hcbp_pkg::TOTAL_WIDTH-1:0] total_bytes
);
    import hcbp_pkg::*;

    mode_t                 in_mode;
    logic                  in_fire;
    logic                  tbl_wr_en;
    logic [CODE_WIDTH-1:0] rd_code;
    logic [LEN_WIDTH-1:0]  rd_len;
    logic                  em_take;
    logic                  em_load;
    emit_t                 em_entry;

    assign in_mode = mode_t'(mode);
    assign in_fire = in_valid && in_ready;

    // loads past the length limit leave the table alone
    assign tbl_wr_en = in_fire && (in_mode == MODE_LOAD)
                       && (code_length <= LEN_WIDTH'(LOAD_LEN_LIMIT));

    // table write and read both happen at the accept edge, so a load is
    // visible to the very next encode transaction
    hcbp_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (tbl_wr_en),
        .wr_addr (symbol),
        .wr_code (code_word),
        .wr_len  (code_length),
        .rd_en   (in_fire),
        .rd_addr (symbol),
        .rd_code (rd_code),
        .rd_len  (rd_len)
    );

    // packing stage: merges the code with the pending bits
    hcbp_packer u_packer (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .in_mode  (in_mode),
        .rd_code  (rd_code),
        .rd_len   (rd_len),
        .em_take  (em_take),
        .in_ready (in_ready),
        .em_load  (em_load),
        .em_entry (em_entry)
    );

    // emitter: one byte per cycle into the output register unless the receiver stalls, keeps the byte count
    hcbp_emitter u_emitter (
        .clk         (clk),
        .rst_n       (rst_n),
        .em_load     (em_load),
        .em_entry    (em_entry),
        .em_take     (em_take),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .byte_valid  (byte_valid),
        .pad_bits    (pad_bits),
        .last        (last),
        .total_bytes (total_bytes)
    );

endmodule

`default_nettype wire

/* hdl/hcbp_table.sv */
`default_nettype none

module hcbp_table (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            wr_en,
    input  wire logic [hcbp_pkg::SYM_WIDTH-1:0]  wr_addr,
    input  wire logic [hcbp_pkg::CODE_WIDTH-1:0] wr_code,
    input  wire logic [hcbp_pkg::LEN_WIDTH-1:0]  wr_len,
    input  wire logic                            rd_en,
    input  wire logic [hcbp_pkg::SYM_WIDTH-1:0]  rd_addr,
    output logic      [hcbp_pkg::CODE_WIDTH-1:0] rd_code,
    output logic      [hcbp_pkg::LEN_WIDTH-1:0]  rd_len
);
    import hcbp_pkg::*;

    logic [CODE_WIDTH+LEN_WIDTH-1:0] mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]          written_reg;
    logic [CODE_WIDTH+LEN_WIDTH-1:0] rd_data_reg;
    logic                            rd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_code, wr_len};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // entries never loaded read as absent
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            rd_hit_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_hit_reg <= written_reg[rd_addr];
            end
        end
    end

    assign rd_code = rd_data_reg[CODE_WIDTH+LEN_WIDTH-1:LEN_WIDTH];
    assign rd_len  = rd_hit_reg ? rd_data_reg[LEN_WIDTH-1:0] : '0;

endmodule

`default_nettype wire

/* hdl/hcbp_packer.sv */
`default_nettype none

module hcbp_packer (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_fire,
    input  wire hcbp_pkg::mode_t                 in_mode,
    input  wire logic [hcbp_pkg::CODE_WIDTH-1:0] rd_code,
    input  wire logic [hcbp_pkg::LEN_WIDTH-1:0]  rd_len,
    input  wire logic                            em_take,
    output logic                                 in_ready,
    output logic                                 em_load,
    output hcbp_pkg::emit_t                      em_entry
);
    import hcbp_pkg::*;

    logic                  s1_valid_reg, s1_valid_next;
    logic                  s1_flush_reg, s1_flush_next;
    logic [PEND_WIDTH-1:0] pend_bits_reg, pend_bits_next;
    logic [PCNT_WIDTH-1:0] pend_cnt_reg, pend_cnt_next;

    logic                  s1_enter;
    logic                  s1_has_res;
    logic                  s1_done;
    logic [CODE_WIDTH-1:0] code_mask;
    logic [ACC_WIDTH-1:0]  enc_acc;
    logic [REM_WIDTH-1:0]  enc_total;
    logic [PEND_WIDTH-1:0] enc_pend_mask;
    logic [PAD_WIDTH-1:0]  fl_pad;
    logic [BYTE_BITS-1:0]  fl_byte;
    logic                  fl_nonempty;

    assign s1_enter = in_fire && ((in_mode == MODE_ENCODE) || (in_mode == MODE_FLUSH));

    // encode: append the masked code under the pending bits
    always_comb
    begin
        if (rd_len >= LEN_WIDTH'(CODE_WIDTH))
        begin
            code_mask = '1;
        end
        else
        begin
            code_mask = (CODE_WIDTH'(1) << rd_len) - CODE_WIDTH'(1);
        end
        enc_acc       = (ACC_WIDTH'(pend_bits_reg) << rd_len)
                        | ACC_WIDTH'(rd_code & code_mask);
        enc_total     = REM_WIDTH'(pend_cnt_reg) + rd_len;
        enc_pend_mask = (PEND_WIDTH'(1) << enc_total[PCNT_WIDTH-1:0]) - PEND_WIDTH'(1);
    end

    // flush: left-align the partial byte
    always_comb
    begin
        fl_nonempty = (pend_cnt_reg != '0);
        fl_pad      = PAD_WIDTH'(PCNT_WIDTH'(0) - pend_cnt_reg);
        fl_byte     = BYTE_BITS'({1'b0, pend_bits_reg} << fl_pad);
    end

    always_comb
    begin
        if (s1_flush_reg)
        begin
            s1_has_res          = 1'b1;
            em_entry.acc        = ACC_WIDTH'(fl_byte);
            em_entry.rem        = REM_WIDTH'(BYTE_BITS);
            em_entry.data_valid = fl_nonempty;
            em_entry.pad        = fl_pad;
        end
        else
        begin
            s1_has_res          = (enc_total >= REM_WIDTH'(BYTE_BITS));
            em_entry.acc        = enc_acc;
            em_entry.rem        = enc_total;
            em_entry.data_valid = 1'b1;
            em_entry.pad        = '0;
        end
    end

    assign s1_done  = s1_valid_reg && (!s1_has_res || em_take);
    assign em_load  = s1_valid_reg && s1_has_res && em_take;
    assign in_ready = !s1_valid_reg || s1_done;

    always_comb
    begin
        s1_valid_next  = (s1_valid_reg && !s1_done) || s1_enter;
        s1_flush_next  = s1_enter ? (in_mode == MODE_FLUSH) : s1_flush_reg;
        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;
        if (s1_done)
        begin
            if (s1_flush_reg)
            begin
                pend_bits_next = '0;
                pend_cnt_next  = '0;
            end
            else
            begin
                pend_bits_next = enc_acc[PEND_WIDTH-1:0] & enc_pend_mask;
                pend_cnt_next  = enc_total[PCNT_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s1_flush_reg  <= 1'b0;
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s1_flush_reg  <= s1_flush_next;
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/hcbp_emitter.sv */
`default_nettype none

module hcbp_emitter (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             em_load,
    input  wire hcbp_pkg::emit_t                  em_entry,
    output logic                                  em_take,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic      [hcbp_pkg::BYTE_BITS-1:0]   out_byte,
    output logic                                  byte_valid,
    output logic      [hcbp_pkg::PAD_WIDTH-1:0]   pad_bits,
    output logic                                  last,
    output logic      [hcbp_pkg::TOTAL_WIDTH-1:0] total_bytes
);
    import hcbp_pkg::*;

    logic [ACC_WIDTH-1:0]   acc_reg, acc_next;
    logic [REM_WIDTH-1:0]   rem_reg, rem_next;
    logic                   dval_reg, dval_next;
    logic [PAD_WIDTH-1:0]   pad_reg, pad_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic                   out_valid_reg, out_valid_next;
    logic [BYTE_BITS-1:0]   out_byte_reg;
    logic                   out_dval_reg;
    logic [PAD_WIDTH-1:0]   out_pad_reg;
    logic                   out_last_reg;
    logic [TOTAL_WIDTH-1:0] out_total_reg;

    logic                   active;
    logic                   is_last;
    logic                   out_load;
    logic [ACC_WIDTH-1:0]   shifted;
    logic [COUNT_WIDTH-1:0] count_inc;

    assign active   = (rem_reg >= REM_WIDTH'(BYTE_BITS));
    assign is_last  = (rem_reg < REM_WIDTH'(2 * BYTE_BITS));
    assign out_load = active && (!out_valid_reg || out_ready);
    assign em_take  = !active || (out_load && is_last);
    assign shifted  = acc_reg >> (rem_reg - REM_WIDTH'(BYTE_BITS));
    assign count_inc = (count_reg == '1) ? count_reg : count_reg + COUNT_WIDTH'(1);

    always_comb
    begin
        acc_next       = acc_reg;
        rem_next       = rem_reg;
        dval_next      = dval_reg;
        pad_next       = pad_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
            rem_next       = rem_reg - REM_WIDTH'(BYTE_BITS);
            if (dval_reg)
            begin
                count_next = count_inc;
            end
        end
        if (em_load)
        begin
            acc_next  = em_entry.acc;
            rem_next  = em_entry.rem;
            dval_next = em_entry.data_valid;
            pad_next  = em_entry.pad;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg       <= '0;
            dval_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rem_reg       <= rem_next;
            dval_reg      <= dval_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        pad_reg <= pad_next;
        if (out_load)
        begin
            out_byte_reg  <= shifted[BYTE_BITS-1:0];
            out_dval_reg  <= dval_reg;
            out_pad_reg   <= pad_reg;
            out_last_reg  <= is_last;
            out_total_reg <= dval_reg ? TOTAL_WIDTH'(count_inc) : TOTAL_WIDTH'(count_reg);
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign byte_valid  = out_dval_reg;
    assign pad_bits    = out_pad_reg;
    assign last        = out_last_reg;
    assign total_bytes = out_total_reg;

endmodule

`default_nettype wire

/* verif/tb_huffman_code_bit_packer_unit.sv */
`timescale 1ns / 100ps

module tb_huffman_code_bit_packer_unit;

    import hcbp_pkg::*;

    // mode 3 has no name in the package: the block drops it
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS  = 70;
    localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
    localparam int IDLE_LIMIT    = 5000;  // cycles with no transaction on either side
    localparam int DRAIN_CYCLES  = 16;    // table read + packing + emitter + output reg, with margin
    localparam int HOLD_AFTER    = 30;    // useful random items before the hold-off starts

    // one output transaction as the block should present it
    typedef struct {
        logic [BYTE_BITS-1:0]   data;
        logic                   valid;
        logic [PAD_WIDTH-1:0]   pad;
        logic                   last_flag;
        logic [TOTAL_WIDTH-1:0] total;
    } packed_out_t;

    // one input transaction; typed_n < 0 means the predictor supplies the results,
    // otherwise typed_n results (0 or 1) are given by hand in typed
    typedef struct {
        logic [1:0]            mode;
        logic [SYM_WIDTH-1:0]  sym;
        logic [CODE_WIDTH-1:0] word;
        logic [LEN_WIDTH-1:0]  len;
        int                    typed_n;
        packed_out_t           typed;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [1:0]             mode = 2'd0;
    logic [SYM_WIDTH-1:0]   symbol = '0;
    logic [CODE_WIDTH-1:0]  code_word = '0;
    logic [LEN_WIDTH-1:0]   code_length = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [BYTE_BITS-1:0]   out_byte;
    logic                   byte_valid;
    logic [PAD_WIDTH-1:0]   pad_bits;
    logic                   last;
    logic [TOTAL_WIDTH-1:0] total_bytes;

    // own copy of the packer state
    logic [CODE_WIDTH-1:0]  code_tab [TABLE_DEPTH];
    logic [LEN_WIDTH-1:0]   len_tab [TABLE_DEPTH];
    logic [PEND_WIDTH-1:0]  held_bits = '0;
    logic [PCNT_WIDTH-1:0]  held_count = '0;
    logic [COUNT_WIDTH-1:0] bytes_sent = '0;

    packed_out_t            expected_bytes_q [$];
    stim_row_t              directed_rows [$];
    logic [SYM_WIDTH-1:0]   loaded_syms [$];

    int                     err_count = 0;
    int                     burst_left = 1;
    logic                   hold_req = 1'b0;

    huffman_code_bit_packer_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .symbol      (symbol),
        .code_word   (code_word),
        .code_length (code_length),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .byte_valid  (byte_valid),
        .pad_bits    (pad_bits),
        .last        (last),
        .total_bytes (total_bytes)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        $display("mismatch at %0t: %s, want %0h got %0h", $realtime, what, want, got);
        err_count++;
    endtask

    // works out the output transactions of one input transaction and moves the
    // packer state on; counter saturates at all ones
    function automatic void predict_packed_bytes(input stim_row_t r, ref packed_out_t res[$]);
        logic [63:0]        acc;
        logic [63:0]        mask;
        int unsigned        clen;
        int unsigned        nbits;
        packed_out_t        o;
        res.delete();
        case (r.mode)
            MODE_LOAD:
            begin
                // too long for the max code length or the code word port: dropped
                if (32'(r.len) <= MAX_CODE_LEN && 32'(r.len) <= CODE_WIDTH)
                begin
                    code_tab[r.sym] = r.word;
                    len_tab[r.sym]  = r.len;
                end
            end
            MODE_ENCODE:
            begin
                clen = 32'(len_tab[r.sym]);
                // absent symbol: nothing at all
                if (clen != 0)
                begin
                    mask  = (64'd1 << clen) - 64'd1;
                    acc   = ({57'd0, held_bits} << clen) | ({32'd0, code_tab[r.sym]} & mask);
                    nbits = 32'(held_count) + clen;
                    while (nbits >= BYTE_BITS)
                    begin
                        nbits -= BYTE_BITS;
                        if (bytes_sent != '1)
                            bytes_sent++;
                        o.data      = acc[nbits +: BYTE_BITS];
                        o.valid     = 1'b1;
                        o.pad       = '0;
                        o.last_flag = (nbits < BYTE_BITS);
                        o.total     = bytes_sent[TOTAL_WIDTH-1:0];
                        res.insert(res.size(), o);
                    end
                    held_bits  = PEND_WIDTH'(acc & ((64'd1 << nbits) - 64'd1));
                    held_count = PCNT_WIDTH'(nbits);
                end
            end
            MODE_FLUSH:
            begin
                o.last_flag = 1'b1;
                o.total     = bytes_sent[TOTAL_WIDTH-1:0];
                if (held_count == '0)
                begin
                    // empty flush: a marker with no data
                    o.data  = '0;
                    o.valid = 1'b0;
                    o.pad   = '0;
                end
                else
                begin
                    o.pad  = PAD_WIDTH'(BYTE_BITS - 32'(held_count));
                    o.data = BYTE_BITS'({1'b0, held_bits} << o.pad);
                    o.valid = 1'b1;
                    if (bytes_sent != '1)
                        bytes_sent++;
                    o.total    = bytes_sent[TOTAL_WIDTH-1:0];
                    held_bits  = '0;
                    held_count = '0;
                end
                res.insert(res.size(), o);
            end
            default:
            begin
                // unused mode: dropped
            end
        endcase
    endfunction

    task automatic add_row(input logic [1:0] m, input logic [SYM_WIDTH-1:0] s,
                           input logic [CODE_WIDTH-1:0] w, input logic [LEN_WIDTH-1:0] l,
                           input int typed_n, input logic typed_valid,
                           input logic [TOTAL_WIDTH-1:0] typed_total);
        stim_row_t r;
        r.mode              = m;
        r.sym               = s;
        r.word              = w;
        r.len               = l;
        r.typed_n           = typed_n;
        // hand-typed results here are always single flush results with no data
        r.typed.data        = '0;
        r.typed.valid       = typed_valid;
        r.typed.pad         = '0;
        r.typed.last_flag   = 1'b1;
        r.typed.total       = typed_total;
        directed_rows.insert(directed_rows.size(), r);
    endtask

    // offers one input transaction, waits for it to go through, then books the
    // expected output and decides whether the burst goes on or a gap follows
    task automatic offer_row(input stim_row_t r);
        packed_out_t res [$];
        int          gap;
        in_valid    <= 1'b1;
        mode        <= r.mode;
        symbol      <= r.sym;
        code_word   <= r.word;
        code_length <= r.len;
        do
            @(posedge clk);
        while (!in_ready);
        predict_packed_bytes(r, res);
        if (r.typed_n < 0)
        begin
            foreach (res[i])
                expected_bytes_q.insert(expected_bytes_q.size(), res[i]);
        end
        else if (r.typed_n > 0)
        begin
            expected_bytes_q.insert(expected_bytes_q.size(), r.typed);
        end
        if (r.mode == MODE_LOAD && 32'(r.len) <= MAX_CODE_LEN && 32'(r.len) <= CODE_WIDTH)
            loaded_syms.insert(loaded_syms.size(), r.sym);
        burst_left--;
        if (burst_left <= 0)
        begin
            // gap with valid low, so valid never drops and rises in one step
            in_valid <= 1'b0;
            gap = $urandom_range(1, 5);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 10);
        end
    endtask

    // random transaction; useful is low for the ones the block just drops
    task automatic make_random_row(output stim_row_t r, output logic useful);
        int roll;
        int lroll;
        roll      = $urandom_range(0, 99);
        r.typed_n = -1;
        r.typed   = '{default: '0};
        r.word    = $urandom;
        r.sym     = SYM_WIDTH'($urandom_range(0, 255));
        r.len     = LEN_WIDTH'($urandom_range(0, 63));
        useful    = 1'b1;
        if (roll < 15)
        begin
            r.mode = MODE_LOAD;
            lroll  = $urandom_range(0, 99);
            if (lroll < 65)
                r.len = LEN_WIDTH'($urandom_range(1, 12));
            else if (lroll < 85)
                r.len = LEN_WIDTH'($urandom_range(13, 32));
            else if (lroll < 92)
                r.len = '0;
            else
            begin
                r.len  = LEN_WIDTH'($urandom_range(33, 63));
                useful = 1'b0;
            end
        end
        else if (roll < 84)
        begin
            r.mode = MODE_ENCODE;
            // mostly symbols with a table entry, now and then an absent one
            if (loaded_syms.size() != 0 && $urandom_range(0, 99) < 88)
                r.sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
            useful = (len_tab[r.sym] != 0);
        end
        else if (roll < 96)
        begin
            r.mode = MODE_FLUSH;
        end
        else
        begin
            r.mode = MODE_UNUSED;
            useful = 1'b0;
        end
    endtask

    // reset and stimulus
    initial
    begin
        stim_row_t r;
        logic      useful;
        int        useful_count;

        // after reset: a flush with nothing pending, absent symbols, dropped transactions
        add_row(MODE_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1, 1'b0, 48'd0);
        add_row(MODE_ENCODE, 8'h41, 32'h0000_0000, 6'd0,  0, 1'b0, 48'd0);
        add_row(MODE_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'd63, 0, 1'b0, 48'd0);
        add_row(MODE_LOAD,   8'h00, 32'hFFFF_FFFF, 6'd33, 0, 1'b0, 48'd0);
        add_row(MODE_LOAD,   8'h00, 32'hFFFF_FFFF, 6'd63, 0, 1'b0, 48'd0);
        add_row(MODE_ENCODE, 8'h00, 32'h0000_0000, 6'd0,  0, 1'b0, 48'd0);
        // longest code, all ones: four bytes from one symbol
        add_row(MODE_LOAD,   8'hFF, 32'hFFFF_FFFF, 6'd32, 0, 1'b0, 48'd0);
        add_row(MODE_ENCODE, 8'hFF, 32'h0000_0000, 6'd0, -1, 1'b0, 48'd0);
        // one-bit code, upper word bits must be ignored; flush pads seven bits
        add_row(MODE_LOAD,   8'h00, 32'hFFFF_FFFE, 6'd1,  0, 1'b0, 48'd0);
        add_row(MODE_ENCODE, 8'h00, 32'h0000_0000, 6'd0, -1, 1'b0, 48'd0);
        add_row(MODE_FLUSH,  8'h00, 32'h0000_0000, 6'd0, -1, 1'b0, 48'd0);
        add_row(MODE_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1, 1'b0, 48'd5);
        // byte-aligned code
        add_row(MODE_LOAD,   8'h80, 32'h0000_00A5, 6'd8,  0, 1'b0, 48'd0);
        add_row(MODE_ENCODE, 8'h80, 32'h0000_0000, 6'd0, -1, 1'b0, 48'd0);
        // 31-bit code twice: second one drains four bytes with bits pending
        add_row(MODE_LOAD,   8'h01, 32'hAAAA_AAAA, 6'd31, 0, 1'b0, 48'd0);
        add_row(MODE_ENCODE, 8'h01, 32'h0000_0000, 6'd0, -1, 1'b0, 48'd0);
        add_row(MODE_ENCODE, 8'h01, 32'h0000_0000, 6'd0, -1, 1'b0, 48'd0);
        add_row(MODE_FLUSH,  8'h00, 32'h0000_0000, 6'd0, -1, 1'b0, 48'd0);
        // zero length load marks the symbol absent
        add_row(MODE_LOAD,   8'h7F, 32'h5555_5555, 6'd0,  0, 1'b0, 48'd0);
        add_row(MODE_ENCODE, 8'h7F, 32'h0000_0000, 6'd0,  0, 1'b0, 48'd0);
        add_row(MODE_LOAD,   8'h02, 32'h1234_5678, 6'd7,  0, 1'b0, 48'd0);
        add_row(MODE_ENCODE, 8'h02, 32'h0000_0000, 6'd0, -1, 1'b0, 48'd0);
        add_row(MODE_ENCODE, 8'hFF, 32'h0000_0000, 6'd0, -1, 1'b0, 48'd0);
        add_row(MODE_FLUSH,  8'h00, 32'h0000_0000, 6'd0, -1, 1'b0, 48'd0);

        foreach (len_tab[i])
            len_tab[i] = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            offer_row(directed_rows[i]);

        // random part: mostly encodes of loaded symbols, with loads, flushes and noise
        useful_count = 0;
        while (useful_count < RANDOM_ITEMS)
        begin
            if (useful_count == HOLD_AFTER)
                hold_req = 1'b1;
            make_random_row(r, useful);
            offer_row(r);
            if (useful)
                useful_count++;
        end
        in_valid <= 1'b0;

        while (expected_bytes_q.size() != 0)
            @(posedge clk);
        // anything still in flight shows up as an unexpected result here
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // receiver: stall pattern of its own, redrawn once every bit of it is used, plus one long
    // hold-off so the pipeline backs up and in_ready drops
    initial
    begin
        logic [15:0] stall_pat;
        int          phase;
        logic        hold_done;
        stall_pat = 16'hFFFF;
        phase     = 0;
        hold_done = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                if (phase == 0)
                begin
                    case ($urandom_range(0, 3))
                        0: stall_pat = 16'hFFFF;
                        1: stall_pat = 16'($urandom);
                        2: stall_pat = 16'($urandom) & 16'($urandom);
                        default: stall_pat = 16'($urandom) | 16'($urandom);
                    endcase
                end
                out_ready <= stall_pat[phase];
                phase = (phase + 1) % 16;
            end
        end
    end

    // output checker: every output transaction against the oldest expectation
    initial
    begin
        packed_out_t e;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (expected_bytes_q.size() == 0)
                begin
                    report_mismatch("output transaction with none expected", 64'd0,
                                    {56'd0, out_byte});
                end
                else
                begin
                    e = expected_bytes_q.pop_front();
                    if (out_byte !== e.data)
                        report_mismatch("out_byte", 64'(e.data), 64'(out_byte));
                    if (byte_valid !== e.valid)
                        report_mismatch("byte_valid", 64'(e.valid), 64'(byte_valid));
                    if (pad_bits !== e.pad)
                        report_mismatch("pad_bits", 64'(e.pad), 64'(pad_bits));
                    if (last !== e.last_flag)
                        report_mismatch("last", 64'(e.last_flag), 64'(last));
                    if (total_bytes !== e.total)
                        report_mismatch("total_bytes", 64'(e.total), 64'(total_bytes));
                end
            end
        end
    end

    // watchdog: too long with no transaction on either side
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        wait (rst_n);
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
